// File: hdl/hps_pkg.sv
// ----------------------------------------------------------------------------
// hps_pkg: shared types and constants for the haptic pattern sequencer
// Register indexes, configuration bundle, field widths and pattern tables.
// ----------------------------------------------------------------------------
`default_nettype none

package hps_pkg;

  localparam int unsigned TIME_W = 32;
  localparam int unsigned TYPE_W = 3;
  localparam int unsigned CONF_W = 13;
  localparam int unsigned STR_W  = 16;
  localparam int unsigned DUTY_W = 8;
  localparam int unsigned GUARD_W = 16;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam int unsigned NUM_TYPES = 8;
  localparam int unsigned MAX_STEPS = 5;
  localparam logic [2:0] LAST_STEP = 3'd4;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_MOTOR_ENABLE   = 3'd0,
    REG_MIN_CONFIDENCE = 3'd1,
    REG_RETRIGGER_MS   = 3'd2,
    REG_MIN_DUTY       = 3'd3,
    REG_MAX_DUTY       = 3'd4
  } hps_reg_idx_t;

  typedef enum logic {
    OP_EVENT = 1'b0,
    OP_TICK  = 1'b1
  } hps_op_t;

  localparam logic [TYPE_W-1:0] TYPE_VOICE = 3'd0;

  typedef struct packed {
    logic                motor_enable;
    logic [CONF_W-1:0]   min_confidence;
    logic [GUARD_W-1:0]  retrigger_guard_ms;
    logic [DUTY_W-1:0]   min_duty;
    logic [DUTY_W-1:0]   max_duty;
  } hps_cfg_t;

  // Step durations in ms, indexed by pattern type then step.
  localparam logic [7:0] PAT_DUR [NUM_TYPES][MAX_STEPS] = '{
    '{8'd110, 8'd70,  8'd110, 8'd0,  8'd0},
    '{8'd75,  8'd55,  8'd75,  8'd55, 8'd75},
    '{8'd90,  8'd0,   8'd0,   8'd0,  8'd0},
    '{8'd220, 8'd80,  8'd80,  8'd0,  8'd0},
    '{8'd150, 8'd120, 8'd150, 8'd0,  8'd0},
    '{8'd100, 8'd0,   8'd0,   8'd0,  8'd0},
    '{8'd100, 8'd0,   8'd0,   8'd0,  8'd0},
    '{8'd100, 8'd0,   8'd0,   8'd0,  8'd0}
  };

  // Motor on during a step.
  localparam logic [MAX_STEPS-1:0] PAT_ON [NUM_TYPES] = '{
    5'b00101,
    5'b10101,
    5'b00001,
    5'b00101,
    5'b00101,
    5'b00001,
    5'b00001,
    5'b00001
  };

  localparam logic [2:0] PAT_COUNT [NUM_TYPES] = '{
    3'd3, 3'd5, 3'd1, 3'd3, 3'd3, 3'd1, 3'd1, 3'd1
  };

endpackage

`default_nettype wire

// File: hdl/hps_in_if.sv
// ----------------------------------------------------------------------------
// hps_in_if: input request channel
// Audio events and time ticks, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface hps_in_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   opcode;
  logic [hps_pkg::TIME_W-1:0]             time_ms;
  logic [hps_pkg::TYPE_W-1:0]             event_type;
  logic [hps_pkg::CONF_W-1:0]             confidence;
  logic signed [hps_pkg::STR_W-1:0]       strength;

  modport source (output valid, opcode, time_ms, event_type, confidence, strength,
                  input ready);
  modport sink   (input valid, opcode, time_ms, event_type, confidence, strength,
                  output ready);
endinterface

`default_nettype wire

// File: hdl/hps_out_if.sv
// ----------------------------------------------------------------------------
// hps_out_if: result channel
// Motor drive value and status per request, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface hps_out_if;
  logic                          valid;
  logic                          ready;
  logic [hps_pkg::DUTY_W-1:0]    left_intensity;
  logic                          pattern_active;
  logic                          event_accepted;

  modport source (output valid, left_intensity, pattern_active, event_accepted,
                  input ready);
  modport sink   (input valid, left_intensity, pattern_active, event_accepted,
                  output ready);
endinterface

`default_nettype wire

// File: hdl/hps_cfg_if.sv
// ----------------------------------------------------------------------------
// hps_cfg_if: configuration write channel
// Register index and write data, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface hps_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [hps_pkg::CFG_ADDR_W-1:0]    addr;
  logic [hps_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

`default_nettype wire

// File: hdl/hps_cfg_regs.sv
// ----------------------------------------------------------------------------
// hps_cfg_regs: configuration register file
// Always ready; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module hps_cfg_regs (
  input  wire logic          clk,
  input  wire logic          rst_n,
  hps_cfg_if.sink            cfg_chan,
  output hps_pkg::hps_cfg_t  cfg
);
  import hps_pkg::*;

  hps_cfg_t cfg_r, cfg_nxt;
  logic     wr;

  assign cfg_chan.ready = 1'b1;
  assign wr = cfg_chan.valid;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      case (cfg_chan.addr)
        REG_MOTOR_ENABLE:   cfg_nxt.motor_enable       = cfg_chan.data[0];
        REG_MIN_CONFIDENCE: cfg_nxt.min_confidence     = cfg_chan.data[CONF_W-1:0];
        REG_RETRIGGER_MS:   cfg_nxt.retrigger_guard_ms = cfg_chan.data[GUARD_W-1:0];
        REG_MIN_DUTY:       cfg_nxt.min_duty           = cfg_chan.data[DUTY_W-1:0];
        REG_MAX_DUTY:       cfg_nxt.max_duty           = cfg_chan.data[DUTY_W-1:0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.motor_enable       <= 1'b1;
      cfg_r.min_confidence     <= 13'd2048;
      cfg_r.retrigger_guard_ms <= 16'd500;
      cfg_r.min_duty           <= 8'd80;
      cfg_r.max_duty           <= 8'd255;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// File: hdl/hps_core.sv
// ----------------------------------------------------------------------------
// hps_core: request register, pattern state update and result register
// One request per cycle unless the output stalls; state is updated in the same pass as the result.
// ----------------------------------------------------------------------------
`default_nettype none

module hps_core (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  hps_pkg::hps_cfg_t  cfg,
  hps_in_if.sink             in_chan,
  hps_out_if.source          out_chan
);
  import hps_pkg::*;

  // request register
  logic                 iv_r;
  logic                 op_r;
  logic [TIME_W-1:0]    time_r;
  logic [TYPE_W-1:0]    etype_r;
  logic [CONF_W-1:0]    conf_r;
  logic signed [STR_W-1:0] str_r;

  // pattern state
  logic                 active_r, active_nxt;
  logic [TYPE_W-1:0]    ptype_r, ptype_nxt;
  logic [2:0]           step_r, step_nxt;
  logic [DUTY_W-1:0]    pulse_r, pulse_nxt;
  logic [TIME_W-1:0]    start_r, start_nxt;
  logic [TIME_W-1:0]    last_r, last_nxt;
  logic [DUTY_W-1:0]    drive_r, drive_nxt;

  // result register
  logic                 ov_r;
  logic [DUTY_W-1:0]    oint_r;
  logic                 oact_r;
  logic                 oacc_r;

  logic advance, fire, take;
  logic accept;

  assign advance = !ov_r || out_chan.ready;
  assign fire    = iv_r && advance;
  assign in_chan.ready = !iv_r || advance;
  assign take    = in_chan.valid && in_chan.ready;

  // intensity = (min*4096 + s*(max-min) + 2048) >> 12, s clamped to 0..4096
  logic [CONF_W-1:0]        s_clamp;
  logic signed [8:0]        duty_diff;
  logic signed [22:0]       duty_prod;
  logic signed [23:0]       duty_num;
  logic [DUTY_W-1:0]        duty_val;

  always_comb begin
    if (str_r[STR_W-1])
      s_clamp = '0;
    else if (str_r > 16'sd4096)
      s_clamp = 13'd4096;
    else
      s_clamp = str_r[CONF_W-1:0];
    duty_diff = $signed({1'b0, cfg.max_duty}) - $signed({1'b0, cfg.min_duty});
    duty_prod = $signed({1'b0, s_clamp}) * duty_diff;
    duty_num  = $signed({4'b0, cfg.min_duty, 12'h800}) + {duty_prod[22], duty_prod};
    duty_val  = duty_num[19:12];
  end

  // acceptance check for events
  logic [TIME_W-1:0] since_last;
  logic              guard_hold;

  assign since_last = time_r - last_r;
  assign guard_hold = (last_r != '0) && (since_last < {16'b0, cfg.retrigger_guard_ms});
  assign accept = (op_r == OP_EVENT) && cfg.motor_enable && (etype_r == TYPE_VOICE)
               && (conf_r >= cfg.min_confidence) && !guard_hold;

  // tick handling
  logic [2:0]        cur_k;
  logic [2:0]        step_inc;
  logic [2:0]        next_k;
  logic [TIME_W-1:0] elapsed;
  logic              step_done;

  always_comb begin
    cur_k     = (step_r > LAST_STEP) ? LAST_STEP : step_r;
    step_inc  = step_r + 3'd1;
    next_k    = (step_inc > LAST_STEP) ? LAST_STEP : step_inc;
    elapsed   = time_r - start_r;
    step_done = elapsed >= {24'b0, PAT_DUR[ptype_r][cur_k]};
  end

  always_comb begin
    active_nxt = active_r;
    ptype_nxt  = ptype_r;
    step_nxt   = step_r;
    pulse_nxt  = pulse_r;
    start_nxt  = start_r;
    last_nxt   = last_r;
    drive_nxt  = drive_r;
    if (op_r == OP_EVENT) begin
      if (accept) begin
        last_nxt   = time_r;
        pulse_nxt  = duty_val;
        ptype_nxt  = etype_r;
        step_nxt   = 3'd0;
        start_nxt  = time_r;
        active_nxt = 1'b1;
        drive_nxt  = PAT_ON[etype_r][0] ? duty_val : '0;
      end
    end else if (active_r && step_done) begin
      step_nxt = step_inc;
      if (step_inc >= PAT_COUNT[ptype_r]) begin
        active_nxt = 1'b0;
        drive_nxt  = '0;
      end else begin
        start_nxt = time_r;
        drive_nxt = PAT_ON[ptype_r][next_k] ? pulse_r : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iv_r     <= 1'b0;
      ov_r     <= 1'b0;
      active_r <= 1'b0;
      ptype_r  <= '0;
      step_r   <= '0;
      pulse_r  <= '0;
      start_r  <= '0;
      last_r   <= '0;
      drive_r  <= '0;
    end else begin
      if (in_chan.ready)
        iv_r <= in_chan.valid;
      if (advance)
        ov_r <= fire;
      if (fire) begin
        active_r <= active_nxt;
        ptype_r  <= ptype_nxt;
        step_r   <= step_nxt;
        pulse_r  <= pulse_nxt;
        start_r  <= start_nxt;
        last_r   <= last_nxt;
        drive_r  <= drive_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      op_r    <= in_chan.opcode;
      time_r  <= in_chan.time_ms;
      etype_r <= in_chan.event_type;
      conf_r  <= in_chan.confidence;
      str_r   <= in_chan.strength;
    end
    if (fire) begin
      oint_r <= drive_nxt;
      oact_r <= active_nxt;
      oacc_r <= accept;
    end
  end

  assign out_chan.valid          = ov_r;
  assign out_chan.left_intensity = oint_r;
  assign out_chan.pattern_active = oact_r;
  assign out_chan.event_accepted = oacc_r;

  // an idle motor is never driven
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !active_r |-> drive_r == '0)
    else $error("drive value nonzero while no pattern plays");

  // a started pattern is always reported as playing
  a_acc_active: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && oacc_r |-> oact_r)
    else $error("accepted event without active pattern");

  // the step counter stays within the pattern while playing
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> step_r < PAT_COUNT[ptype_r])
    else $error("step number past end of pattern");

  // a stalled result holds the pending request in place
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    iv_r && !advance |=> iv_r && $stable(time_r))
    else $error("pending request lost during output stall");

  // state only moves when a request is processed
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> $stable(active_r) && $stable(step_r) && $stable(last_r))
    else $error("pattern state changed without a request");

endmodule

`default_nettype wire

// File: hdl/haptic_pattern_sequencer.sv
// ----------------------------------------------------------------------------
// haptic_pattern_sequencer: voice-triggered vibration pattern player
// Turns classified audio events and millisecond ticks into a left motor drive.
// ----------------------------------------------------------------------------
// Usage:
//  - in_chan carries one request per handshake: an audio event (opcode 0)
//    or a time tick (opcode 1), with a millisecond timestamp.
//  - out_chan returns exactly one result per request, in order: the current
//    left motor drive, the pattern-playing flag and whether that request
//    started a pattern.
//  - cfg_chan writes the five control registers (enable, confidence
//    threshold, retrigger guard, min/max duty); always ready. Write only
//    while no request is in flight.
//  - An accepted request passes through the request register, then the
//    result register. Throughput: one request per cycle unless stalled;
//    the pattern state is updated in the same pass that forms the result.
//  - Receiver stall: the result register holds, the request register
//    fills, then in_chan.ready drops; nothing is lost or repeated.
//  - Reset (rst_n low, synchronous): registers return to defaults, the
//    pattern stops, no event has been seen yet, both channels are empty.
// ----------------------------------------------------------------------------
`default_nettype none

module haptic_pattern_sequencer (
  input  wire logic  clk,
  input  wire logic  rst_n,
  hps_in_if.sink     in_chan,
  hps_out_if.source  out_chan,
  hps_cfg_if.sink    cfg_chan
);
  import hps_pkg::*;

  hps_cfg_t cfg;

  // control registers
  hps_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_chan (cfg_chan),
    .cfg      (cfg)
  );

  // request handling and pattern sequencing
  hps_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

endmodule

`default_nettype wire
